FILE: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; they compile away under SYNTHESIS.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// Check prop on every edge outside reset.
`define BTI_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("bti assertion failed");
// Check prop on every edge, reset included.
`define BTI_ASSERT_ALWAYS(lbl, clk, prop) \
   lbl: assert property (@(posedge clk) prop) \
      else $error("bti assertion failed");
`else
`define BTI_ASSERT(lbl, clk, rst, prop)
`define BTI_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

FILE: rtl/bti_pkg.sv
// ----------------------------------------------------------------------------
// bti_pkg
// Types and constants shared by the table interpolator controller and datapath.
// ----------------------------------------------------------------------------
package bti_pkg;

   localparam int VAL_W  = 32;
   localparam int CNT_W  = 5;
   localparam int FRAC_W = 17;

   // command codes
   localparam logic [1:0] CMD_WR_X    = 2'd0;
   localparam logic [1:0] CMD_WR_Y    = 2'd1;
   localparam logic [1:0] CMD_WR_GRID = 2'd2;
   localparam logic [1:0] CMD_QUERY   = 2'd3;

   // region codes
   localparam logic [2:0] REGION_EMPTY    = 3'd0;
   localparam logic [2:0] REGION_LOW      = 3'd1;
   localparam logic [2:0] REGION_HIGH     = 3'd2;
   localparam logic [2:0] REGION_Y_EDGE   = 3'd3;
   localparam logic [2:0] REGION_X_EDGE   = 3'd4;
   localparam logic [2:0] REGION_INTERIOR = 3'd5;

   // configuration register indexes
   localparam logic [7:0] CSR_COUNT_X = 8'd0;
   localparam logic [7:0] CSR_COUNT_Y = 8'd1;

   typedef struct packed {
      logic       accept;
      logic       search_step;
      logic       classify;
      logic [1:0] fetch_rd_sel;
      logic       fetch_ld;
      logic [1:0] fetch_ld_sel;
      logic       diff_load;
      logic       div_init;
      logic       div_axis;
      logic       div_step;
      logic       frac_store_a;
      logic       frac_store_b;
      logic       mul_en;
      logic [2:0] mul_phase;
   } dp_cmd_type;

   typedef struct packed {
      logic search_done;
   } dp_stat_type;

endpackage

FILE: rtl/bti_ctrl.sv
// ----------------------------------------------------------------------------
// bti_ctrl
// Query sequencer: search, classify, fetch, two divisions, multiply-accumulate.
// ----------------------------------------------------------------------------
module bti_ctrl import bti_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [1:0]  req_command,
   input  dp_stat_type stat,
   output dp_cmd_type  cmd,
   output logic        busy,
   output logic        rsp_valid
);

   localparam logic [CNT_W-1:0] FETCH_LAST = CNT_W'(4);
   localparam logic [CNT_W-1:0] DIV_LAST   = CNT_W'(FRAC_W - 1);
   localparam logic [CNT_W-1:0] MUL_LAST   = CNT_W'(4);

   typedef enum logic [2:0] {
      ST_IDLE, ST_SEARCH, ST_CLASSIFY, ST_FETCH,
      ST_DIV_INIT, ST_DIV_STEP, ST_DIV_STORE, ST_MUL
   } state_type;

   state_type        state_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic [CNT_W-1:0] cnt_dec;
   logic             axis_ff;
   logic             busy_ff;
   logic             valid_ff;

   assign busy      = busy_ff;
   assign rsp_valid = valid_ff;
   assign cnt_dec   = cnt_ff - CNT_W'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
         axis_ff  <= 1'b0;
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start && req_command == CMD_QUERY) begin
                  state_ff <= ST_SEARCH;
                  busy_ff  <= 1'b1;
               end
            end
            ST_SEARCH: begin
               if (stat.search_done) state_ff <= ST_CLASSIFY;
            end
            ST_CLASSIFY: begin
               state_ff <= ST_FETCH;
               cnt_ff   <= '0;
            end
            ST_FETCH: begin
               if (cnt_ff == FETCH_LAST) begin
                  state_ff <= ST_DIV_INIT;
                  axis_ff  <= 1'b0;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            ST_DIV_INIT: begin
               state_ff <= ST_DIV_STEP;
               cnt_ff   <= '0;
            end
            ST_DIV_STEP: begin
               if (cnt_ff == DIV_LAST) state_ff <= ST_DIV_STORE;
               else cnt_ff <= cnt_ff + CNT_W'(1);
            end
            ST_DIV_STORE: begin
               if (!axis_ff) begin
                  axis_ff  <= 1'b1;
                  state_ff <= ST_DIV_INIT;
               end else begin
                  state_ff <= ST_MUL;
                  cnt_ff   <= '0;
               end
            end
            ST_MUL: begin
               if (cnt_ff == MUL_LAST) begin
                  state_ff <= ST_IDLE;
                  busy_ff  <= 1'b0;
                  valid_ff <= 1'b1;
               end else begin
                  cnt_ff <= cnt_ff + CNT_W'(1);
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   always_comb begin
      cmd        = '0;
      cmd.accept = start & ~busy_ff;
      unique case (state_ff)
         ST_IDLE:     ;
         ST_SEARCH:   cmd.search_step = ~stat.search_done;
         ST_CLASSIFY: cmd.classify = 1'b1;
         ST_FETCH: begin
            cmd.fetch_rd_sel = cnt_ff[1:0];
            cmd.fetch_ld     = (cnt_ff != '0);
            cmd.fetch_ld_sel = cnt_dec[1:0];
         end
         ST_DIV_INIT: begin
            cmd.div_init  = 1'b1;
            cmd.div_axis  = axis_ff;
            cmd.diff_load = ~axis_ff;
         end
         ST_DIV_STEP: cmd.div_step = 1'b1;
         ST_DIV_STORE: begin
            cmd.frac_store_a = ~axis_ff;
            cmd.frac_store_b = axis_ff;
         end
         ST_MUL: begin
            cmd.mul_en    = 1'b1;
            cmd.mul_phase = cnt_ff[2:0];
         end
         default: ;
      endcase
   end

endmodule

FILE: rtl/bti_datapath.sv
// ----------------------------------------------------------------------------
// bti_datapath
// Tables, breakpoint search, cell selection, divider and multiply-accumulate.
// ----------------------------------------------------------------------------
module bti_datapath import bti_pkg::*; #(
   parameter int MAX_X = 16,
   parameter int MAX_Y = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_stat_type             stat,
   input  logic [1:0]              req_command,
   input  logic [7:0]              req_write_index,
   input  logic signed [VAL_W-1:0] req_write_value,
   input  logic signed [VAL_W-1:0] req_arg_x,
   input  logic signed [VAL_W-1:0] req_arg_y,
   input  logic                    csr_we,
   input  logic [7:0]              csr_index,
   input  logic [31:0]             csr_wdata,
   output logic signed [VAL_W-1:0] value_out,
   output logic [2:0]              region
);

   localparam int XB_W       = (MAX_X > 1) ? $clog2(MAX_X) : 1;
   localparam int YB_W       = (MAX_Y > 1) ? $clog2(MAX_Y) : 1;
   localparam int GRID_SIZE  = MAX_X * MAX_Y;
   localparam int GRID_DEPTH = (GRID_SIZE < 256) ? GRID_SIZE : 256;
   localparam int GA_W       = (GRID_DEPTH > 1) ? $clog2(GRID_DEPTH) : 1;

   // configuration
   logic [CNT_W-1:0] count_x_ff, count_y_ff, cx, cy;
   logic             empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_x_ff <= CNT_W'(1);
         count_y_ff <= CNT_W'(1);
      end else if (csr_we) begin
         if (csr_index == CSR_COUNT_X) count_x_ff <= csr_wdata[CNT_W-1:0];
         else if (csr_index == CSR_COUNT_Y) count_y_ff <= csr_wdata[CNT_W-1:0];
      end
   end

   assign cx    = (32'(count_x_ff) > MAX_X) ? CNT_W'(MAX_X) : count_x_ff;
   assign cy    = (32'(count_y_ff) > MAX_Y) ? CNT_W'(MAX_Y) : count_y_ff;
   assign empty = (cx == '0) || (cy == '0);

   // tables
   logic signed [VAL_W-1:0] xbp_mem  [MAX_X];
   logic signed [VAL_W-1:0] ybp_mem  [MAX_Y];
   logic signed [VAL_W-1:0] grid_mem [GRID_DEPTH];
   logic signed [VAL_W-1:0] xbp_rd_ff, ybp_rd_ff, grid_rd_ff;

   logic [CNT_W-1:0] ptr_ff, ptr_in;
   logic [7:0]       ptr_ext;
   logic             wr_x, wr_y, wr_grid;
   logic [9:0]       grid_addr;

   assign ptr_in  = cmd.accept ? '0 : (cmd.search_step ? ptr_ff + CNT_W'(1) : ptr_ff);
   assign ptr_ext = 8'(ptr_in);

   assign wr_x    = cmd.accept && req_command == CMD_WR_X && 32'(req_write_index) < MAX_X;
   assign wr_y    = cmd.accept && req_command == CMD_WR_Y && 32'(req_write_index) < MAX_Y;
   assign wr_grid = cmd.accept && req_command == CMD_WR_GRID &&
                    32'(req_write_index) < GRID_SIZE;

   always_ff @(posedge clock) begin
      if (wr_x) xbp_mem[req_write_index[XB_W-1:0]] <= req_write_value;
      xbp_rd_ff <= xbp_mem[ptr_ext[XB_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_y) ybp_mem[req_write_index[YB_W-1:0]] <= req_write_value;
      ybp_rd_ff <= ybp_mem[ptr_ext[YB_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (wr_grid) grid_mem[req_write_index[GA_W-1:0]] <= req_write_value;
      grid_rd_ff <= grid_mem[grid_addr[GA_W-1:0]];
   end

   // breakpoint search, both axes side by side
   logic signed [VAL_W-1:0] arg_x_ff, arg_y_ff, xprev_ff, yprev_ff;
   logic signed [VAL_W-1:0] x_lo_ff, x_hi_ff, y_lo_ff, y_hi_ff;
   logic [CNT_W-1:0]        ix_ff, iy_ff;
   logic                    x_done_ff, y_done_ff, x_hit, y_hit, x_last, y_last;

   function automatic logic seg_hit(input logic [CNT_W-1:0] k,
                                    input logic signed [VAL_W-1:0] arg,
                                    input logic signed [VAL_W-1:0] prev,
                                    input logic signed [VAL_W-1:0] cur);
      seg_hit = (k == '0) ? (arg <= cur) : (prev <= arg && arg <= cur);
   endfunction

   assign x_hit  = seg_hit(ptr_ff, arg_x_ff, xprev_ff, xbp_rd_ff);
   assign y_hit  = seg_hit(ptr_ff, arg_y_ff, yprev_ff, ybp_rd_ff);
   assign x_last = (ptr_ff == cx - CNT_W'(1));
   assign y_last = (ptr_ff == cy - CNT_W'(1));

   assign stat.search_done = empty || (x_done_ff && y_done_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         ptr_ff    <= '0;
         x_done_ff <= 1'b0;
         y_done_ff <= 1'b0;
      end else begin
         ptr_ff <= ptr_in;
         if (cmd.accept) begin
            x_done_ff <= 1'b0;
            y_done_ff <= 1'b0;
         end else if (cmd.search_step) begin
            if (x_hit || x_last) x_done_ff <= 1'b1;
            if (y_hit || y_last) y_done_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         arg_x_ff <= req_arg_x;
         arg_y_ff <= req_arg_y;
      end
      if (cmd.search_step) begin
         xprev_ff <= xbp_rd_ff;
         yprev_ff <= ybp_rd_ff;
         if (!x_done_ff && (x_hit || x_last)) begin
            ix_ff   <= x_hit ? ptr_ff : cx;
            x_lo_ff <= xprev_ff;
            x_hi_ff <= xbp_rd_ff;
         end
         if (!y_done_ff && (y_hit || y_last)) begin
            iy_ff   <= y_hit ? ptr_ff : cy;
            y_lo_ff <= yprev_ff;
            y_hi_ff <= ybp_rd_ff;
         end
      end
   end

   // cell selection
   logic [CNT_W-1:0] row0_in, row1_in, col0_in, col1_in;
   logic [CNT_W-1:0] row0_ff, row1_ff, col0_ff, col1_ff;
   logic             use_a_in, use_b_in, avg_in, use_a_ff, use_b_ff, avg_ff;
   logic [2:0]       region_in, region_ff;

   always_comb begin
      row0_in   = '0;
      row1_in   = '0;
      col0_in   = '0;
      col1_in   = '0;
      use_a_in  = 1'b0;
      use_b_in  = 1'b0;
      avg_in    = 1'b0;
      region_in = REGION_LOW;
      priority if (empty) begin
         region_in = REGION_EMPTY;
      end else if (ix_ff == '0 && iy_ff == '0) begin
         region_in = REGION_LOW;
      end else if (ix_ff == cx && iy_ff == cy) begin
         region_in = REGION_HIGH;
         row0_in   = cy - CNT_W'(1);
         row1_in   = cy - CNT_W'(1);
         col0_in   = cx - CNT_W'(1);
         col1_in   = cx - CNT_W'(1);
      end else if (ix_ff == '0 || ix_ff == cx) begin
         region_in = REGION_Y_EDGE;
         col0_in   = (ix_ff == '0) ? '0 : cx - CNT_W'(1);
         col1_in   = col0_in;
         if (iy_ff == '0) begin
            row0_in = '0;
            row1_in = '0;
         end else if (iy_ff >= cy) begin
            row0_in = cy - CNT_W'(1);
            row1_in = cy - CNT_W'(1);
         end else begin
            row0_in  = iy_ff - CNT_W'(1);
            row1_in  = iy_ff;
            avg_in   = (y_lo_ff == y_hi_ff);
            use_b_in = (y_lo_ff != y_hi_ff);
         end
      end else if (iy_ff == '0 || iy_ff == cy) begin
         region_in = REGION_X_EDGE;
         row0_in   = (iy_ff == '0) ? '0 : cy - CNT_W'(1);
         row1_in   = row0_in;
         col0_in   = ix_ff - CNT_W'(1);
         col1_in   = ix_ff;
         avg_in    = (x_lo_ff == x_hi_ff);
         use_a_in  = (x_lo_ff != x_hi_ff);
      end else begin
         region_in = REGION_INTERIOR;
         row0_in   = iy_ff - CNT_W'(1);
         row1_in   = iy_ff;
         col0_in   = ix_ff - CNT_W'(1);
         col1_in   = ix_ff;
         use_a_in  = 1'b1;
         use_b_in  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.classify) begin
         row0_ff   <= row0_in;
         row1_ff   <= row1_in;
         col0_ff   <= col0_in;
         col1_ff   <= col1_in;
         use_a_ff  <= use_a_in;
         use_b_ff  <= use_b_in;
         avg_ff    <= avg_in;
         region_ff <= region_in;
      end
   end

   // corner fetch
   logic [CNT_W-1:0]        fetch_row, fetch_col;
   logic signed [VAL_W-1:0] f11_ff, f12_ff, f21_ff, f22_ff;

   assign fetch_row = cmd.fetch_rd_sel[1] ? row1_ff : row0_ff;
   assign fetch_col = cmd.fetch_rd_sel[0] ? col1_ff : col0_ff;
   assign grid_addr = 10'(fetch_row) * 10'(cx) + 10'(fetch_col);

   always_ff @(posedge clock) begin
      if (cmd.fetch_ld) begin
         unique case (cmd.fetch_ld_sel)
            2'd0: f11_ff <= grid_rd_ff;
            2'd1: f12_ff <= grid_rd_ff;
            2'd2: f21_ff <= grid_rd_ff;
            2'd3: f22_ff <= grid_rd_ff;
            default: ;
         endcase
      end
   end

   // corner differences
   logic signed [32:0] d1_ff, d2_ff, e_ff;
   logic signed [34:0] d3_ff;

   always_ff @(posedge clock) begin
      if (cmd.diff_load) begin
         d1_ff <= 33'(f12_ff) - 33'(f11_ff);
         d2_ff <= 33'(f21_ff) - 33'(f11_ff);
         e_ff  <= 33'(f22_ff) - 33'(f21_ff);
      end
      if (cmd.frac_store_a) d3_ff <= 35'(e_ff) - 35'(d1_ff);
   end

   // fraction divider, one quotient bit per step
   logic signed [VAL_W-1:0] div_arg, div_lo, div_hi;
   logic [32:0]             div_off, div_span, den_ff, rem_keep;
   logic [33:0]             rem_ff, rem_sub;
   logic                    rem_ge;
   logic [FRAC_W-1:0]       quo_ff, a_ff, b_ff, ab_ff;

   assign div_arg  = cmd.div_axis ? arg_y_ff : arg_x_ff;
   assign div_lo   = cmd.div_axis ? y_lo_ff : x_lo_ff;
   assign div_hi   = cmd.div_axis ? y_hi_ff : x_hi_ff;
   assign div_off  = 33'(div_arg) - 33'(div_lo);
   assign div_span = 33'(div_hi) - 33'(div_lo);
   assign rem_ge   = rem_ff >= {1'b0, den_ff};
   assign rem_sub  = rem_ff - {1'b0, den_ff};
   assign rem_keep = rem_ge ? rem_sub[32:0] : rem_ff[32:0];

   always_ff @(posedge clock) begin
      if (cmd.div_init) begin
         rem_ff <= {1'b0, div_off};
         den_ff <= div_span;
         quo_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff <= {rem_keep, 1'b0};
         quo_ff <= {quo_ff[FRAC_W-2:0], rem_ge};
      end
      if (cmd.frac_store_a) a_ff <= (use_a_ff && den_ff != '0) ? quo_ff : '0;
      if (cmd.frac_store_b) b_ff <= (use_b_ff && den_ff != '0) ? quo_ff : '0;
   end

   // shared multiplier and accumulator
   logic signed [FRAC_W:0] mul_a;
   logic signed [34:0]     mul_b;
   logic signed [52:0]     prod_ff;
   logic signed [36:0]     prod_sh;
   logic signed [39:0]     acc_ff, acc_fin;
   logic signed [32:0]     avg_sum;
   logic signed [VAL_W-1:0] sat_val, value_out_ff;
   logic [2:0]             region_out_ff;

   always_comb begin
      unique case (cmd.mul_phase)
         3'd0: begin mul_a = signed'({1'b0, a_ff});  mul_b = signed'(35'(b_ff)); end
         3'd1: begin mul_a = signed'({1'b0, a_ff});  mul_b = 35'(d1_ff);          end
         3'd2: begin mul_a = signed'({1'b0, b_ff});  mul_b = 35'(d2_ff);          end
         default: begin mul_a = signed'({1'b0, ab_ff}); mul_b = d3_ff;           end
      endcase
   end

   assign prod_sh = prod_ff[52:16];
   assign acc_fin = acc_ff + 40'(prod_sh);
   assign avg_sum = 33'(f12_ff) + 33'(f21_ff);
   assign sat_val = (acc_fin[39:31] == '0 || acc_fin[39:31] == '1) ? acc_fin[31:0] :
                    (acc_fin[39] ? 32'sh8000_0000 : 32'sh7fff_ffff);

   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         prod_ff <= mul_a * mul_b;
         unique case (cmd.mul_phase)
            3'd0: ;
            3'd1: ab_ff  <= prod_ff[32:16];
            3'd2: acc_ff <= 40'(f11_ff) + 40'(prod_sh);
            3'd3: acc_ff <= acc_fin;
            default: begin
               region_out_ff <= region_ff;
               if (region_ff == REGION_EMPTY) value_out_ff <= '0;
               else if (avg_ff) value_out_ff <= avg_sum[32:1];
               else value_out_ff <= sat_val;
            end
         endcase
      end
   end

   assign value_out = value_out_ff;
   assign region    = region_out_ff;

endmodule

FILE: rtl/bilinear_table_interpolator_unit.sv
// ----------------------------------------------------------------------------
// bilinear_table_interpolator_unit
// Q16.16 two-axis lookup table with bilinear interpolation, loaded by command.
// ----------------------------------------------------------------------------
// Each transaction is taken when start is high and busy is low. Writes of
// X/Y breakpoints and grid entries (row-major, row * count_x + column) land
// on the accepting edge and never raise busy or produce a response. A query
// raises busy and returns exactly one response: rsp_valid pulses for one
// cycle with rsp_value_out and rsp_region, and there is no way to hold it off,
// so sample it on that cycle. The X and Y searches run side by side, one
// breakpoint per cycle through the registered read port of each breakpoint
// memory, then the two fractions go through a restoring divider one after
// the other and a shared multiplier runs five passes. Busy drops on the
// strobe cycle, so the next transaction can be taken while the result is on
// the ports. Counts are set through the csr_ port (index 0 count_x, 1 count_y,
// reset 1) only while idle; a count of zero answers 0 in the empty region.
// Breakpoint and grid memories are not cleared: query only entries that were
// written.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bilinear_table_interpolator_unit import bti_pkg::*; #(
   parameter int MAX_X = 16,
   parameter int MAX_Y = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   // command channel
   input  logic                    start,
   output logic                    busy,
   input  logic [1:0]              req_command,
   input  logic [7:0]              req_write_index,
   input  logic signed [VAL_W-1:0] req_write_value,
   input  logic signed [VAL_W-1:0] req_arg_x,
   input  logic signed [VAL_W-1:0] req_arg_y,
   // response strobe
   output logic                    rsp_valid,
   output logic signed [VAL_W-1:0] rsp_value_out,
   output logic [2:0]              rsp_region,
   // configuration writes
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_index,
   input  logic [31:0]             csr_wdata
);

   dp_cmd_type  cmd;
   dp_stat_type stat;

   // take register writes whenever no query is in flight
   assign csr_ready = ~busy;

   bti_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .stat        (stat),
      .cmd         (cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid)
   );

   bti_datapath #(
      .MAX_X (MAX_X),
      .MAX_Y (MAX_Y)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_command     (req_command),
      .req_write_index (req_write_index),
      .req_write_value (req_write_value),
      .req_arg_x       (req_arg_x),
      .req_arg_y       (req_arg_y),
      .csr_we          (csr_valid & csr_ready),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .value_out       (rsp_value_out),
      .region          (rsp_region)
   );

   // response strobe lasts exactly one cycle
   `BTI_ASSERT(a_rsp_single, clock, reset, rsp_valid |=> !rsp_valid)
   // a response only ends a busy period
   `BTI_ASSERT(a_rsp_after_busy, clock, reset, rsp_valid |-> $past(busy))
   // a table write never starts a busy period
   `BTI_ASSERT(a_write_no_busy, clock, reset, start && !busy && req_command != CMD_QUERY |=> !busy)
   // a query always starts one
   `BTI_ASSERT(a_query_busy, clock, reset, start && !busy && req_command == CMD_QUERY |=> busy)

endmodule

FILE: tb/sv/bilinear_table_interpolator_unit_test.sv
// ----------------------------------------------------------------------------
// bilinear_table_interpolator_unit_test
// Self-checking bench: loads breakpoint lists and grids by command, queries
// the table, checking responses against an in-bench interpolator or set values.
// ----------------------------------------------------------------------------
module bilinear_table_interpolator_unit_test;
   import bti_pkg::*;

   localparam int NX = 16;
   localparam int NY = 16;
   localparam int RANDOM_ITEMS = 800;
   localparam logic [31:0] S_MAX = 32'h7FFF_FFFF;
   localparam logic [31:0] S_MIN = 32'h8000_0000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   logic [1:0] req_command = CMD_WR_X;
   logic [7:0] req_write_index = '0;
   logic signed [31:0] req_write_value = '0;
   logic signed [31:0] req_arg_x = '0;
   logic signed [31:0] req_arg_y = '0;
   logic rsp_valid;
   logic signed [31:0] rsp_value_out;
   logic [2:0] rsp_region;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [7:0] csr_index = '0;
   logic [31:0] csr_wdata = '0;

   bilinear_table_interpolator_unit dut (
      .clock, .reset, .start, .busy,
      .req_command, .req_write_index, .req_write_value, .req_arg_x, .req_arg_y,
      .rsp_valid, .rsp_value_out, .rsp_region,
      .csr_valid, .csr_ready, .csr_index, .csr_wdata
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Shadow copy of the table and the counts
   logic signed [31:0] x_bp [NX];
   logic signed [31:0] y_bp [NY];
   logic signed [31:0] cells [NX*NY];
   logic [4:0] count_x_q = 5'd1;
   logic [4:0] count_y_q = 5'd1;

   typedef struct {
      logic signed [31:0] value;
      logic [2:0]         region;
   } lookup_t;

   lookup_t pending_lookups [$];
   int errors = 0;
   int gap_max = 15;

   function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return S_MAX;
      if (v < -64'sd2147483648) return S_MIN;
      return v[31:0];
   endfunction

   function automatic logic signed [31:0] bp_at(bit on_y, int i);
      return on_y ? y_bp[i] : x_bp[i];
   endfunction

   // First segment holding arg; 0 below the list, n past it
   function automatic int segment_of(bit on_y, int n, logic signed [31:0] arg);
      if (arg <= bp_at(on_y, 0)) return 0;
      for (int i = 1; i < n; i++)
         if (arg >= bp_at(on_y, i - 1) && arg <= bp_at(on_y, i)) return i;
      return n;
   endfunction

   function automatic longint fraction(logic signed [31:0] arg, logic signed [31:0] lo,
                                       logic signed [31:0] hi);
      longint span;
      longint off;
      span = longint'(hi) - longint'(lo);
      off = longint'(arg) - longint'(lo);
      if (span == 0) return 0;
      return (off <<< 16) / span;
   endfunction

   function automatic logic signed [31:0] edge_value(logic signed [31:0] arg, bit on_y,
                                                     int n, int idx, int base, int stride);
      longint f1;
      longint f2;
      longint fr;
      if (idx == 0) return cells[base];
      if (idx >= n) return cells[base + (n - 1) * stride];
      f1 = cells[base + (idx - 1) * stride];
      f2 = cells[base + idx * stride];
      // zero-width segment: floor average of its ends
      if (bp_at(on_y, idx - 1) == bp_at(on_y, idx)) return clamp32((f1 + f2) >>> 1);
      fr = fraction(arg, bp_at(on_y, idx - 1), bp_at(on_y, idx));
      return clamp32(f1 + (((f2 - f1) * fr) >>> 16));
   endfunction

   function automatic lookup_t interpolate(logic signed [31:0] ax, logic signed [31:0] ay);
      lookup_t r;
      int cx;
      int cy;
      int ix;
      int iy;
      longint f11, f12, f21, f22, a, b, ab, sum;
      cx = (count_x_q > NX) ? NX : count_x_q;
      cy = (count_y_q > NY) ? NY : count_y_q;
      if (cx == 0 || cy == 0) begin
         r.value = '0; r.region = REGION_EMPTY;
         return r;
      end
      ix = segment_of(1'b0, cx, ax);
      iy = segment_of(1'b1, cy, ay);
      if (ix == 0 && iy == 0) begin
         r.value = cells[0]; r.region = REGION_LOW;
      end else if (ix == cx && iy == cy) begin
         r.value = cells[cx * cy - 1]; r.region = REGION_HIGH;
      end else if (ix == 0) begin
         r.value = edge_value(ay, 1'b1, cy, iy, 0, cx); r.region = REGION_Y_EDGE;
      end else if (ix == cx) begin
         r.value = edge_value(ay, 1'b1, cy, iy, cx - 1, cx); r.region = REGION_Y_EDGE;
      end else if (iy == 0) begin
         r.value = edge_value(ax, 1'b0, cx, ix, 0, 1); r.region = REGION_X_EDGE;
      end else if (iy == cy) begin
         r.value = edge_value(ax, 1'b0, cx, ix, (cy - 1) * cx, 1); r.region = REGION_X_EDGE;
      end else begin
         f11 = cells[(iy - 1) * cx + ix - 1];
         f12 = cells[(iy - 1) * cx + ix];
         f21 = cells[iy * cx + ix - 1];
         f22 = cells[iy * cx + ix];
         a = fraction(ax, x_bp[ix - 1], x_bp[ix]);
         b = fraction(ay, y_bp[iy - 1], y_bp[iy]);
         ab = (a * b) >>> 16;
         sum = f11 + ((a * (f12 - f11)) >>> 16) + ((b * (f21 - f11)) >>> 16)
             + ((ab * (f11 - f12 - f21 + f22)) >>> 16);
         r.value = clamp32(sum); r.region = REGION_INTERIOR;
      end
      return r;
   endfunction

   // Apply one accepted command to the shadow table; queue the lookup a query yields
   function automatic void apply_command(logic [1:0] cmd, logic [7:0] idx,
                                         logic signed [31:0] wv, logic signed [31:0] ax,
                                         logic signed [31:0] ay);
      case (cmd)
         CMD_WR_X: if (idx < NX) x_bp[idx] = wv;
         CMD_WR_Y: if (idx < NY) y_bp[idx] = wv;
         CMD_WR_GRID: if (idx < NX * NY) cells[idx] = wv;
         default: pending_lookups.push_back(interpolate(ax, ay));
      endcase
   endfunction

   // Present one transaction after a random gap and hold it until taken
   task automatic issue(logic [1:0] cmd, logic [7:0] idx, logic signed [31:0] wv,
                        logic signed [31:0] ax, logic signed [31:0] ay);
      int gap;
      gap = $urandom_range(0, gap_max);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_command <= cmd;
      req_write_index <= idx;
      req_write_value <= wv;
      req_arg_x <= ax;
      req_arg_y <= ay;
      do @(posedge clock); while (busy);
   endtask

   // Drop start and hold until every query has answered
   task automatic drain();
      start <= 1'b0;
      do @(posedge clock); while (busy || pending_lookups.size() != 0);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_COUNT_X) count_x_q = data[4:0];
      else if (idx == CSR_COUNT_Y) count_y_q = data[4:0];
   endtask

   // Check every response strobe against the oldest pending lookup
   always @(posedge clock) begin
      lookup_t want;
      if (!reset && rsp_valid) begin
         if (pending_lookups.size() == 0) begin
            $error("unexpected response value_out=%0d region=%0d", rsp_value_out, rsp_region);
            errors++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_value_out !== want.value) begin
               $error("value_out expected %0d actual %0d", want.value, rsp_value_out);
               errors++;
            end
            if (rsp_region !== want.region) begin
               $error("region expected %0d actual %0d", want.region, rsp_region);
               errors++;
            end
         end
      end
   end

   typedef struct {
      bit                 is_csr;
      logic [1:0]         cmd;
      logic [7:0]         idx;
      logic [31:0]        wv;
      logic [31:0]        ax;
      logic [31:0]        ay;
      bit                 typed;
      logic [31:0]        want_value;
      logic [2:0]         want_region;
   } stim_row_t;

   localparam int DIRECTED_ROWS = 30;
   // Directed rows: count 1 corners and edges, empty table, full counts, extreme
   // cells, ignored writes, oversized count, duplicate breakpoints
   stim_row_t directed [DIRECTED_ROWS] = '{
      '{0, CMD_QUERY, 0, 0, S_MIN, S_MIN, 1, 0, REGION_LOW},
      '{0, CMD_QUERY, 0, 0, S_MAX, S_MAX, 1, 0, REGION_HIGH},
      '{0, CMD_QUERY, 0, 0, S_MIN, S_MAX, 1, 0, REGION_Y_EDGE},
      '{0, CMD_QUERY, 0, 0, S_MAX, S_MIN, 1, 0, REGION_Y_EDGE},
      '{1, CMD_QUERY, CSR_COUNT_X, 0, 0, 0, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 0, 0, 1, 0, REGION_EMPTY},
      '{1, CMD_QUERY, CSR_COUNT_X, 16, 0, 0, 0, 0, 0},
      '{1, CMD_QUERY, CSR_COUNT_Y, 16, 0, 0, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, S_MAX, S_MIN, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, S_MIN, 32'h0007_8000, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h0002_8000, 32'h0003_4000, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h000F_0000, 32'h000F_0000, 0, 0, 0},
      '{0, CMD_WR_GRID, 238, S_MAX, 0, 0, 0, 0, 0},
      '{0, CMD_WR_GRID, 239, S_MIN, 0, 0, 0, 0, 0},
      '{0, CMD_WR_GRID, 254, S_MIN, 0, 0, 0, 0, 0},
      '{0, CMD_WR_GRID, 255, S_MAX, 0, 0, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h000E_8000, 32'h000E_8000, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h000E_C000, 32'h000E_4000, 0, 0, 0},
      '{0, CMD_WR_X, 200, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{0, CMD_WR_Y, 16, 32'hFFFF_FFFF, 0, 0, 0, 0, 0},
      '{0, CMD_WR_GRID, 0, S_MIN, 0, 0, 0, 0, 0},
      '{1, CMD_QUERY, CSR_COUNT_X, 31, 0, 0, 0, 0, 0},
      '{1, CMD_QUERY, CSR_COUNT_Y, 2, 0, 0, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, S_MIN, S_MIN, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h0005_8000, 32'h0000_8000, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h0005_8000, S_MAX, 0, 0, 0},
      '{0, CMD_WR_X, 3, 32'h0002_0000, 0, 0, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h0002_0000, 32'h0000_4000, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h0002_8000, 32'h0000_C000, 0, 0, 0},
      '{0, CMD_QUERY, 0, 0, 32'h0003_0000, S_MAX, 0, 0, 0}
   };

   function automatic logic signed [31:0] random_value();
      if ($urandom_range(0, 7) == 0) return $urandom;
      return $signed($urandom_range(0, 32'h01FF_FFFF)) - 32'sh0100_0000;
   endfunction

   // Argument near the breakpoint span, on a breakpoint, or anywhere
   function automatic logic signed [31:0] random_arg(bit on_y, int n);
      longint lo;
      longint hi;
      longint pick;
      int m;
      m = (n < 1) ? 1 : ((n > NX) ? NX : n);
      case ($urandom_range(0, 7))
         0: return $urandom;
         1: return bp_at(on_y, $urandom_range(0, m - 1));
         default: begin
            lo = bp_at(on_y, 0);
            hi = bp_at(on_y, m - 1);
            if (hi < lo) begin
               pick = lo; lo = hi; hi = pick;
            end
            lo = lo - 32'sd131072;
            hi = hi + 32'sd131072;
            pick = lo + longint'({$urandom, $urandom} % (hi - lo + 1));
            return clamp32(pick);
         end
      endcase
   endfunction

   // Ascending list, with repeats now and then; sometimes plain noise
   task automatic load_breakpoints(logic [1:0] cmd);
      longint v;
      bit noise;
      noise = ($urandom_range(0, 7) == 0);
      v = $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      for (int i = 0; i < NX; i++) begin
         issue(cmd, i[7:0], noise ? $urandom : clamp32(v), 0, 0);
         apply_command(cmd, i[7:0], noise ? req_write_value : clamp32(v), 0, 0);
         if ($urandom_range(0, 9) != 0) v += $urandom_range(1, 32'h0004_0000);
      end
   endtask

   initial begin
      int done_items;
      int cx;
      int cy;
      logic [1:0] cmd;
      logic [7:0] idx;
      logic signed [31:0] wv;
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Load every entry so no query reads an unwritten location
      for (int i = 0; i < NX; i++) begin
         issue(CMD_WR_X, i[7:0], i << 16, 0, 0);
         apply_command(CMD_WR_X, i[7:0], i << 16, 0, 0);
         issue(CMD_WR_Y, i[7:0], i << 16, 0, 0);
         apply_command(CMD_WR_Y, i[7:0], i << 16, 0, 0);
      end
      for (int i = 0; i < NX * NY; i++) begin
         issue(CMD_WR_GRID, i[7:0], (i * 3) << 14, 0, 0);
         apply_command(CMD_WR_GRID, i[7:0], (i * 3) << 14, 0, 0);
      end

      // Walk the directed table
      foreach (directed[r]) begin
         if (directed[r].is_csr) begin
            drain();
            write_csr(directed[r].idx, directed[r].wv);
         end else begin
            issue(directed[r].cmd, directed[r].idx, directed[r].wv, directed[r].ax,
                  directed[r].ay);
            if (directed[r].typed) begin
               pending_lookups.push_back('{directed[r].want_value, directed[r].want_region});
            end else begin
               apply_command(directed[r].cmd, directed[r].idx, directed[r].wv,
                             directed[r].ax, directed[r].ay);
            end
         end
      end

      // Random phases: new counts, fresh breakpoints, then mixed traffic
      done_items = 0;
      while (done_items < RANDOM_ITEMS) begin
         drain();
         case ($urandom_range(0, 9))
            0: begin cx = 0; cy = $urandom_range(1, 16); end
            1: begin cx = 31; cy = 16; end
            2: begin cx = 1; cy = $urandom_range(1, 31); end
            3: begin cx = 16; cy = 16; end
            default: begin cx = $urandom_range(2, 16); cy = $urandom_range(2, 16); end
         endcase
         if ($urandom_range(0, 1)) begin
            write_csr(CSR_COUNT_X, cx);
            write_csr(CSR_COUNT_Y, cy);
         end else begin
            write_csr(CSR_COUNT_Y, cy);
            write_csr(CSR_COUNT_X, cx);
         end
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : 15;
         load_breakpoints(CMD_WR_X);
         load_breakpoints(CMD_WR_Y);
         done_items += 2 * NX;
         for (int k = 0; k < 60; k++) begin
            case ($urandom_range(0, 9))
               0: begin
                  cmd = $urandom_range(0, 1) ? CMD_WR_X : CMD_WR_Y;
                  idx = $urandom;
                  wv = random_value();
               end
               1, 2: begin
                  cmd = CMD_WR_GRID;
                  idx = $urandom;
                  wv = random_value();
               end
               default: begin
                  cmd = CMD_QUERY;
                  idx = $urandom;
                  wv = $urandom;
               end
            endcase
            ax = random_arg(1'b0, cx);
            ay = random_arg(1'b1, cy);
            issue(cmd, idx, wv, ax, ay);
            apply_command(cmd, idx, wv, ax, ay);
            done_items++;
         end
      end

      drain();
      repeat (100) @(posedge clock);
      if (errors == 0 && pending_lookups.size() == 0) begin
         $display("tb: success");
      end else begin
         if (pending_lookups.size() != 0)
            $error("%0d expected responses never arrived", pending_lookups.size());
         $display("tb: failure");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("tb: failure");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/bti_pkg.sv
rtl/bti_ctrl.sv
rtl/bti_datapath.sv
rtl/bilinear_table_interpolator_unit.sv
tb/sv/bilinear_table_interpolator_unit_test.sv
